// ----- rtl/lad_pkg.sv -----
// ----------------------------------------------------------------------------
// lad_pkg
// Shared widths and codes for the linear array double-ended queue.
// ----------------------------------------------------------------------------
package lad_pkg;

	localparam int FUNC_W = 3;
	localparam int ELEM_W = 32;
	localparam int POS_W  = 4;
	localparam int STAT_W = 3;
	localparam int CAP_W  = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_FRONT_INS = 3'd0,
		FN_FRONT_DEL = 3'd1,
		FN_REAR_INS  = 3'd2,
		FN_REAR_DEL  = 3'd3,
		FN_DISPLAY   = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 3'd0,
		ST_REFUSED = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_ELEM    = 3'd4
	} status_t;

endpackage

// ----- rtl/lad_if.sv -----
// ----------------------------------------------------------------------------
// lad_cmd_if / lad_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lad_cmd_if;
	logic                              valid;
	logic                              ready;
	logic        [lad_pkg::FUNC_W-1:0] func;
	logic signed [lad_pkg::ELEM_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface lad_rsp_if;
	logic                              valid;
	logic                              ready;
	logic        [lad_pkg::STAT_W-1:0] status;
	logic signed [lad_pkg::POS_W-1:0]  front_pos;
	logic signed [lad_pkg::POS_W-1:0]  rear_pos;
	logic signed [lad_pkg::ELEM_W-1:0] elem_value;
	logic                              last;

	modport source (output valid, output status, output front_pos, output rear_pos,
		output elem_value, output last, input ready);
	modport sink (input valid, input status, input front_pos, input rear_pos,
		input elem_value, input last, output ready);
endinterface

// ----- rtl/lad_ram.sv -----
// ----------------------------------------------------------------------------
// lad_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Read data holds until the next read is issued.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/linear_array_deque_top.sv -----
// ----------------------------------------------------------------------------
// linear_array_deque_top
// Linear (non-circular) double-ended queue kept in a RAM, with front and
// rear indices that both read -1 while the queue is empty.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cmd       in   valid/ready    func, value
//  rsp       out  valid/ready    status, front_pos, rear_pos, elem_value, last
//  cfg       in   cfg_we         cfg_wdata (capacity)
//
// Insert, delete and empty display each give one item on rsp.
// A display of n elements goes through the accept, the first RAM read in
// S_READ, then S_SHOW with one element a cycle through the registered read
// port while rsp is not stalled. A stall on rsp holds the RAM read data and the
// walk pointer, and holds cmd.ready low while a result item waits.
// Reset sets both indices to -1 and capacity to 8; the RAM is not cleared.
// ----------------------------------------------------------------------------
module linear_array_deque_top #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lad_cmd_if.sink                    cmd,
	lad_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [lad_pkg::CAP_W-1:0]  cfg_wdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = $clog2(DEPTH + 1) + 1;
	localparam int CW = (IW > lad_pkg::CAP_W) ? IW : lad_pkg::CAP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SHOW
	} state_t;

	state_t                            state_q;
	logic signed [IW-1:0]              front_q;
	logic signed [IW-1:0]              rear_q;
	logic signed [IW-1:0]              ptr_q;
	logic [lad_pkg::CAP_W-1:0]         capacity_q;

	logic                              out_valid_q;
	lad_pkg::status_t                  status_q;
	logic signed [lad_pkg::ELEM_W-1:0] elem_q;
	logic                              last_q;

	logic                              can_load;
	logic                              accept;
	lad_pkg::func_t                    func;
	logic                              empty;
	logic [CW-1:0]                     cap_w;
	logic signed [IW-1:0]              rear_inc;
	logic signed [IW-1:0]              front_dec;
	logic                              rear_full;
	logic                              ptr_last;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic                              ram_re;
	logic [AW-1:0]                     ram_raddr;
	logic [lad_pkg::ELEM_W-1:0]        ram_rdata;

	assign can_load  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && can_load;
	assign accept    = cmd.valid && cmd.ready;
	assign func      = lad_pkg::func_t'(cmd.func);

	assign empty     = (front_q == -IW'(1));
	assign rear_inc  = rear_q + IW'(1);
	assign front_dec = front_q - IW'(1);
	assign cap_w     = (CW'(capacity_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_q);
	// rear_inc is never negative, so its magnitude bits compare as unsigned.
	assign rear_full = CW'(rear_inc[IW-2:0]) >= cap_w;
	assign ptr_last  = (ptr_q == rear_q);

	// A rear insert into an empty queue lands in slot 0, which is rear + 1 as well.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rear_inc[AW-1:0];
		if (accept && func == lad_pkg::FN_FRONT_INS && front_q > 0) begin
			ram_we    = 1'b1;
			ram_waddr = front_dec[AW-1:0];
		end else if (accept && func == lad_pkg::FN_REAR_INS && !rear_full) begin
			ram_we    = 1'b1;
			ram_waddr = rear_inc[AW-1:0];
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		if (state_q == S_READ) begin
			ram_re = 1'b1;
		end else if (state_q == S_SHOW && can_load && !ptr_last) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(ptr_q + IW'(1));
		end
	end

	lad_ram #(
		.WIDTH (lad_pkg::ELEM_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= -IW'(1);
			rear_q      <= -IW'(1);
			ptr_q       <= '0;
			capacity_q  <= lad_pkg::CAP_W'(8);
			out_valid_q <= 1'b0;
			status_q    <= lad_pkg::ST_DONE;
			elem_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						elem_q <= '0;
						last_q <= 1'b1;
						unique case (func)
							lad_pkg::FN_FRONT_INS: begin
								out_valid_q <= 1'b1;
								if (front_q > 0) begin
									front_q  <= front_dec;
									status_q <= lad_pkg::ST_DONE;
								end else begin
									status_q <= lad_pkg::ST_REFUSED;
								end
							end
							lad_pkg::FN_FRONT_DEL, lad_pkg::FN_REAR_DEL: begin
								out_valid_q <= 1'b1;
								status_q    <= lad_pkg::ST_DONE;
								if (empty) begin
									status_q <= lad_pkg::ST_EMPTY;
								end else if (front_q == rear_q) begin
									front_q <= -IW'(1);
									rear_q  <= -IW'(1);
								end else if (func == lad_pkg::FN_FRONT_DEL) begin
									front_q <= front_q + IW'(1);
								end else begin
									rear_q <= rear_q - IW'(1);
								end
							end
							lad_pkg::FN_REAR_INS: begin
								out_valid_q <= 1'b1;
								if (rear_full) begin
									status_q <= lad_pkg::ST_FULL;
								end else begin
									status_q <= lad_pkg::ST_DONE;
									rear_q   <= rear_inc;
									if (empty) begin
										front_q <= '0;
									end
								end
							end
							lad_pkg::FN_DISPLAY: begin
								if (empty) begin
									out_valid_q <= 1'b1;
									status_q    <= lad_pkg::ST_EMPTY;
								end else begin
									ptr_q   <= front_q;
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						status_q    <= lad_pkg::ST_ELEM;
						elem_q      <= ram_rdata;
						last_q      <= ptr_last;
						if (ptr_last) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.front_pos  = lad_pkg::POS_W'(front_q);
	assign rsp.rear_pos   = lad_pkg::POS_W'(rear_q);
	assign rsp.elem_value = elem_q;
	assign rsp.last       = last_q;

endmodule

// ----- dv/linear_array_deque_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_array_deque_top_tb
// Drives command items into the deque with random gaps and random result
// stalls, predicts every result item from a shadow copy of the array and
// both indices, and checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module linear_array_deque_top_tb;

	localparam int DEPTH = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = DEPTH + 4;
	localparam logic [lad_pkg::FUNC_W-1:0] FN_RESERVED_MIN = 3'd5;
	localparam logic [lad_pkg::FUNC_W-1:0] FN_RESERVED_MAX = 3'd7;
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct {
		lad_pkg::status_t                  status;
		logic signed [lad_pkg::POS_W-1:0]  front_pos;
		logic signed [lad_pkg::POS_W-1:0]  rear_pos;
		logic signed [lad_pkg::ELEM_W-1:0] elem_value;
		logic                              last;
	} deque_rsp_t;

	class deque_tracker;
		logic [lad_pkg::ELEM_W-1:0] slot_mem [DEPTH];
		int                         front_idx;
		int                         rear_idx;
		logic [lad_pkg::CAP_W-1:0]  cap_reg;
		deque_rsp_t                 pending[$];
		int                         errors;

		function new();
			front_idx = -1;
			rear_idx = -1;
			cap_reg = lad_pkg::CAP_W'(8);
			errors = 0;
		endfunction

		function void set_capacity(logic [lad_pkg::CAP_W-1:0] c);
			cap_reg = c;
		endfunction

		function void add_rsp(lad_pkg::status_t st, logic [lad_pkg::ELEM_W-1:0] elem,
				logic fin);
			deque_rsp_t r;
			r.status = st;
			r.front_pos = lad_pkg::POS_W'(front_idx);
			r.rear_pos = lad_pkg::POS_W'(rear_idx);
			r.elem_value = elem;
			r.last = fin;
			pending.push_back(r);
		endfunction

		function void apply_cmd(logic [lad_pkg::FUNC_W-1:0] f,
				logic [lad_pkg::ELEM_W-1:0] v);
			int eff_cap;
			eff_cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
			case (f)
				lad_pkg::FN_FRONT_INS: begin
					if (front_idx > 0 && front_idx <= DEPTH) begin
						front_idx--;
						slot_mem[front_idx] = v;
						add_rsp(lad_pkg::ST_DONE, '0, 1'b1);
					end else begin
						add_rsp(lad_pkg::ST_REFUSED, '0, 1'b1);
					end
				end
				lad_pkg::FN_FRONT_DEL, lad_pkg::FN_REAR_DEL: begin
					if (front_idx == -1) begin
						add_rsp(lad_pkg::ST_EMPTY, '0, 1'b1);
					end else begin
						// Taking the only element empties the queue.
						if (front_idx == rear_idx) begin
							front_idx = -1;
							rear_idx = -1;
						end else if (f == lad_pkg::FN_FRONT_DEL) begin
							front_idx++;
						end else begin
							rear_idx--;
						end
						add_rsp(lad_pkg::ST_DONE, '0, 1'b1);
					end
				end
				lad_pkg::FN_REAR_INS: begin
					if (rear_idx + 1 >= eff_cap) begin
						add_rsp(lad_pkg::ST_FULL, '0, 1'b1);
					end else if (front_idx == -1) begin
						slot_mem[0] = v;
						front_idx = 0;
						rear_idx = 0;
						add_rsp(lad_pkg::ST_DONE, '0, 1'b1);
					end else begin
						rear_idx++;
						slot_mem[rear_idx] = v;
						add_rsp(lad_pkg::ST_DONE, '0, 1'b1);
					end
				end
				lad_pkg::FN_DISPLAY: begin
					if (front_idx == -1) begin
						add_rsp(lad_pkg::ST_EMPTY, '0, 1'b1);
					end else begin
						for (int i = front_idx; i <= rear_idx && i >= 0 && i < DEPTH; i++)
							add_rsp(lad_pkg::ST_ELEM, slot_mem[i], i == rear_idx);
					end
				end
				default: ;
			endcase
		endfunction

		function void match_rsp(logic [lad_pkg::STAT_W-1:0] st,
				logic signed [lad_pkg::POS_W-1:0] fp, logic signed [lad_pkg::POS_W-1:0] rp,
				logic signed [lad_pkg::ELEM_W-1:0] ev, logic lst);
			deque_rsp_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item: status %0d front %0d rear %0d elem %0d last %0b",
					$time, st, fp, rp, ev, lst);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (st !== exp_r.status || fp !== exp_r.front_pos || rp !== exp_r.rear_pos
					|| ev !== exp_r.elem_value || lst !== exp_r.last) begin
				$display("%0t: mismatch: expected status %0d front %0d rear %0d elem %0d last %0b",
					$time, exp_r.status, exp_r.front_pos, exp_r.rear_pos, exp_r.elem_value,
					exp_r.last);
				$display("%0t:           actual status %0d front %0d rear %0d elem %0d last %0b",
					$time, st, fp, rp, ev, lst);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [lad_pkg::CAP_W-1:0] cfg_wdata;
	logic                      calm;

	lad_cmd_if cmd_if();
	lad_rsp_if rsp_if();

	deque_tracker tracker;

	linear_array_deque_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [lad_pkg::ELEM_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [lad_pkg::FUNC_W-1:0] pick_func(int mode);
		int r;
		int c_fi, c_fd, c_ri, c_rd;
		r = $urandom_range(0, 99);
		if (r < 4)
			return lad_pkg::FUNC_W'($urandom_range(FN_RESERVED_MIN, FN_RESERVED_MAX));
		case (mode)
			MODE_FILL: begin
				c_fi = 24; c_fd = 40; c_ri = 84; c_rd = 89;
			end
			MODE_DRAIN: begin
				c_fi = 12; c_fd = 44; c_ri = 56; c_rd = 86;
			end
			default: begin
				c_fi = 24; c_fd = 44; c_ri = 72; c_rd = 86;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < c_fi)
			return lad_pkg::FN_FRONT_INS;
		if (r < c_fd)
			return lad_pkg::FN_FRONT_DEL;
		if (r < c_ri)
			return lad_pkg::FN_REAR_INS;
		if (r < c_rd)
			return lad_pkg::FN_REAR_DEL;
		return lad_pkg::FN_DISPLAY;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is
	// taken, with valid still high so back-to-back items need no gap.
	task automatic push_cmd(input logic [lad_pkg::FUNC_W-1:0] f,
			input logic [lad_pkg::ELEM_W-1:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid = 1'b1;
		cmd_if.func = f;
		cmd_if.value = v;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		tracker.apply_cmd(f, v);
		@(negedge clk);
	endtask

	// The capacity only changes once all results are out and the block has
	// had time to finish any walk that produced no result.
	task automatic write_capacity(input logic [lad_pkg::CAP_W-1:0] c);
		cmd_if.valid = 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = c;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_capacity(c);
	endtask

	task automatic run_directed();
		push_cmd(lad_pkg::FN_DISPLAY, $urandom);
		push_cmd(lad_pkg::FN_FRONT_INS, 32'h1234_5678);
		push_cmd(lad_pkg::FN_FRONT_DEL, $urandom);
		push_cmd(lad_pkg::FN_REAR_DEL, $urandom);
		push_cmd(lad_pkg::FN_REAR_INS, 32'h8000_0000);
		push_cmd(lad_pkg::FN_FRONT_DEL, $urandom);
		push_cmd(lad_pkg::FN_REAR_INS, 32'h7fff_ffff);
		push_cmd(lad_pkg::FN_REAR_INS, 32'h0000_0000);
		push_cmd(lad_pkg::FN_REAR_INS, 32'hffff_ffff);
		push_cmd(lad_pkg::FN_FRONT_DEL, $urandom);
		push_cmd(lad_pkg::FN_FRONT_INS, 32'h5555_5555);
		push_cmd(lad_pkg::FN_FRONT_INS, 32'haaaa_aaaa);
		push_cmd(lad_pkg::FN_DISPLAY, $urandom);
		push_cmd(lad_pkg::FN_REAR_DEL, $urandom);
		push_cmd(FN_RESERVED_MIN, $urandom);
		push_cmd(FN_RESERVED_MAX, $urandom);
		push_cmd(lad_pkg::FN_DISPLAY, $urandom);
		// Capacity drops below the current fill, so the next rear insert is full.
		write_capacity(lad_pkg::CAP_W'(1));
		push_cmd(lad_pkg::FN_REAR_INS, 32'h1111_1111);
		push_cmd(lad_pkg::FN_REAR_DEL, $urandom);
		push_cmd(lad_pkg::FN_REAR_DEL, $urandom);
		push_cmd(lad_pkg::FN_REAR_INS, 32'h0f0f_0f0f);
		push_cmd(lad_pkg::FN_REAR_INS, 32'hf0f0_f0f0);
		push_cmd(lad_pkg::FN_DISPLAY, $urandom);
	endtask

	task automatic run_random_phase(input logic [lad_pkg::CAP_W-1:0] cap, input int count);
		int n;
		int mode;
		logic [lad_pkg::FUNC_W-1:0] f;
		write_capacity(cap);
		calm = ($urandom_range(0, 3) == 0);
		n = 0;
		mode = MODE_FILL;
		while (n < count) begin
			if (n % 12 == 0)
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
			f = pick_func(mode);
			push_cmd(f, pick_value());
			if (f <= lad_pkg::FN_DISPLAY)
				n++;
		end
	endtask

	// Result side: ready drops for random stretches.
	initial begin
		int stall;
		logic rdy;
		stall = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rdy = 1'b0;
				stall--;
			end else begin
				rdy = 1'b1;
				stall = idle_len();
			end
			rsp_if.ready = rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			tracker.match_rsp(rsp_if.status, rsp_if.front_pos, rsp_if.rear_pos,
				rsp_if.elem_value, rsp_if.last);
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
					|| (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("linear_array_deque_top_tb NOT OK");
		$finish;
	end

	initial begin
		tracker = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.func = '0;
		cmd_if.value = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_random_phase(lad_pkg::CAP_W'(0), 20);
		run_random_phase(lad_pkg::CAP_W'(15), 43);
		run_random_phase(lad_pkg::CAP_W'(8), 43);
		run_random_phase(lad_pkg::CAP_W'(5), 43);
		run_random_phase(lad_pkg::CAP_W'(2), 43);
		run_random_phase(lad_pkg::CAP_W'($urandom_range(0, 15)), 43);
		run_random_phase(lad_pkg::CAP_W'(8), 43);
		run_random_phase(lad_pkg::CAP_W'(12), 43);
		run_random_phase(lad_pkg::CAP_W'($urandom_range(0, 15)), 43);

		cmd_if.valid = 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("linear_array_deque_top_tb OK");
		end else begin
			$display("linear_array_deque_top_tb NOT OK");
		end
		$finish;
	end

endmodule
